@@ hw/rtl/sdff_pkg.sv @@
// Shared types, constants and helpers for the signed decimal field formatter.
// Used by every module of the block; depends on nothing else.
package sdff_pkg;

    // Fixed widths of the ports and of the configuration fields.
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int LEN_PORT_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Default values of the top level parameters.
    localparam int MAX_FIELD_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Decimal digit store: ten digits cover any 32-bit magnitude.
    localparam int DIGITS    = 10;
    localparam int DIG_W     = 4;
    localparam int DIG_IDX_W = 4;

    // Width used for run length arithmetic before clipping.
    localparam int LEN_W = 8;

    // Layout modes; any other code behaves as plain width padding.
    localparam logic [1:0] MODE_WIDTH = 2'd0;
    localparam logic [1:0] MODE_ZERO  = 2'd1;
    localparam logic [1:0] MODE_PREC  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREC_GIVEN = 3'd4;

    // Characters.
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef logic [DIGITS-1:0][DIG_W-1:0] digits_t;

    typedef struct packed {
        logic [1:0] layout_mode;
        logic [6:0] field_width;
        logic [5:0] digit_precision;
        logic       left_justify;
        logic       precision_given;
    } cfg_t;

    // Difference floored at zero.
    function automatic logic [LEN_W-1:0] sub_floor(input logic [LEN_W-1:0] a,
                                                   input logic [LEN_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

@@ hw/rtl/sdff_bcd.sv @@
// Binary to decimal converter for the formatter: a shift-and-add-three unit
// that takes one magnitude bit per cycle. Depends on sdff_pkg.
module sdff_bcd #(
    parameter int VALUE_BITS = sdff_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] mag,
    output logic                  busy,
    output logic                  done,
    output sdff_pkg::digits_t     digits
);
    import sdff_pkg::*;

    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int FLAT_W = DIGITS * DIG_W;

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    digits_t               bcd_reg, bcd_next;
    digits_t               adjusted;
    logic [FLAT_W-1:0]     adjusted_flat;

    // Each digit of five or more gets three added before the shift, so that
    // it carries correctly into the next digit.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adjusted[i] = (bcd_reg[i] >= DIG_W'(5)) ? (bcd_reg[i] + DIG_W'(3)) : bcd_reg[i];
        end
    end

    assign adjusted_flat = adjusted;
    assign done          = busy_reg && (cnt_reg == '0);
    assign busy          = busy_reg;
    assign digits        = bcd_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(VALUE_BITS - 1);
            shift_next = mag;
            bcd_next   = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next   = {adjusted_flat[FLAT_W-2:0], shift_reg[VALUE_BITS-1]};
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

endmodule

@@ hw/rtl/sdff_emit.sv @@
// Layout planner and character sequencer for the formatter: sizes the space
// and zero runs, then sends one character per beat. Depends on sdff_pkg.
module sdff_emit #(
    parameter int MAX_FIELD = sdff_pkg::MAX_FIELD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                neg,
    input  sdff_pkg::digits_t                   digits,
    input  sdff_pkg::cfg_t                      cfg,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [sdff_pkg::CHAR_W-1:0]         char_out,
    output logic                                last_char,
    output logic [sdff_pkg::LEN_PORT_W-1:0]     total_length,
    output logic                                busy
);
    import sdff_pkg::*;

    localparam int CW = $clog2(MAX_FIELD + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIG   = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_SPACE = 3'd3;
    localparam logic [2:0] ST_BOUND = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [DIG_W-1:0]  dcnt_reg, dcnt_next;
    logic [CW-1:0]     zeros_reg, zeros_next;
    logic [CW-1:0]     spaces_reg, spaces_next;
    logic [CW-1:0]     lead_end_reg, lead_end_next;
    logic [CW-1:0]     sign_end_reg, sign_end_next;
    logic [CW-1:0]     zero_end_reg, zero_end_next;
    logic [CW-1:0]     dig_end_reg, dig_end_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     len_reg, len_next;

    logic [LEN_W-1:0]     sd, body, limit, run_raw;
    logic [DIG_W-1:0]     count;
    logic [CW-1:0]        lead, dig_pos;
    logic [DIG_IDX_W-1:0] dig_idx;

    // Number of significant digits, at least one so that zero prints as '0'.
    always_comb
    begin
        count = DIG_W'(1);
        for (int i = 1; i < DIGITS; i++)
        begin
            if (digits[i] != '0)
            begin
                count = DIG_W'(i + 1);
            end
        end
    end

    assign sd      = LEN_W'(neg) + LEN_W'(dcnt_reg);
    assign body    = sd + LEN_W'(zeros_reg);
    assign lead    = cfg.left_justify ? '0 : spaces_reg;
    assign dig_pos = dig_end_reg - CW'(1) - pos_reg;
    assign dig_idx = dig_pos[DIG_IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        dcnt_next     = dcnt_reg;
        zeros_next    = zeros_reg;
        spaces_next   = spaces_reg;
        lead_end_next = lead_end_reg;
        sign_end_next = sign_end_reg;
        zero_end_next = zero_end_reg;
        dig_end_next  = dig_end_reg;
        total_next    = total_reg;
        pos_next      = pos_reg;
        valid_next    = valid_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        len_next      = len_reg;
        run_raw       = '0;
        limit         = '0;

        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIG;
                end
            end
            ST_DIG:
            begin
                dcnt_next  = count;
                state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                unique case (cfg.layout_mode)
                    MODE_ZERO:
                    begin
                        run_raw = cfg.precision_given
                                  ? sub_floor(LEN_W'(cfg.digit_precision), LEN_W'(dcnt_reg))
                                  : sub_floor(LEN_W'(cfg.field_width), sd);
                    end
                    MODE_PREC:
                    begin
                        run_raw = sub_floor(LEN_W'(cfg.digit_precision), LEN_W'(dcnt_reg));
                    end
                    default:
                    begin
                        run_raw = '0;
                    end
                endcase
                // Zero fill is cut so that sign, zeros and digits still fit.
                limit      = LEN_W'(MAX_FIELD) - sd;
                zeros_next = (run_raw > limit) ? limit[CW-1:0] : run_raw[CW-1:0];
                state_next = ST_SPACE;
            end
            ST_SPACE:
            begin
                unique case (cfg.layout_mode)
                    MODE_ZERO:
                    begin
                        run_raw = '0;
                    end
                    MODE_PREC:
                    begin
                        run_raw = sub_floor(LEN_W'(cfg.field_width), body);
                    end
                    default:
                    begin
                        run_raw = sub_floor(LEN_W'(cfg.field_width), sd);
                    end
                endcase
                limit       = LEN_W'(MAX_FIELD) - body;
                spaces_next = (run_raw > limit) ? limit[CW-1:0] : run_raw[CW-1:0];
                state_next  = ST_BOUND;
            end
            ST_BOUND:
            begin
                lead_end_next = lead;
                sign_end_next = lead + CW'(neg);
                zero_end_next = lead + CW'(neg) + zeros_reg;
                dig_end_next  = lead + body[CW-1:0];
                total_next    = body[CW-1:0] + spaces_reg;
                pos_next      = '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!valid_reg || !out_stall)
                begin
                    valid_next = 1'b1;
                    if (pos_reg < lead_end_reg)
                    begin
                        char_next = CHAR_SPACE;
                    end
                    else if (pos_reg < sign_end_reg)
                    begin
                        char_next = CHAR_MINUS;
                    end
                    else if (pos_reg < zero_end_reg)
                    begin
                        char_next = CHAR_ZERO;
                    end
                    else if (pos_reg < dig_end_reg)
                    begin
                        char_next = CHAR_ZERO + CHAR_W'(digits[dig_idx]);
                    end
                    else
                    begin
                        char_next = CHAR_SPACE;
                    end
                    pos_next = pos_reg + CW'(1);
                    if (pos_reg == total_reg - CW'(1))
                    begin
                        last_next  = 1'b1;
                        len_next   = total_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        last_next = 1'b0;
                        len_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dcnt_reg     <= dcnt_next;
        zeros_reg    <= zeros_next;
        spaces_reg   <= spaces_next;
        lead_end_reg <= lead_end_next;
        sign_end_reg <= sign_end_next;
        zero_end_reg <= zero_end_next;
        dig_end_reg  <= dig_end_next;
        total_reg    <= total_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
        len_reg      <= len_next;
    end

    assign out_valid    = valid_reg;
    assign char_out     = char_reg;
    assign last_char    = last_reg;
    assign total_length = LEN_PORT_W'(len_reg);
    assign busy         = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/signed_decimal_field_formatter.sv @@
// Top level of the signed decimal field formatter: configuration registers,
// input beat capture and sign handling. Depends on sdff_pkg, sdff_bcd, sdff_emit.
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ------------------------------------
//  in       into block in_valid / in_stall   value
//  out      from block out_valid / out_stall char_out, last_char, total_length
//  cfg      into block cfg_valid / cfg_ready cfg_index, cfg_data
//
// One number passes through the shift-and-add-three converter, which consumes
// one magnitude bit per cycle, then through the planning states ST_DIG, ST_ZERO,
// ST_SPACE and ST_BOUND, then is sent out (one to MAX_FIELD characters).
// The next number is taken once the last character sits in the output register.
// Reset is asynchronous and active low; it returns the configuration to zero and
// the sequencer to idle. A stall on the output simply holds the sequencer in place.
module signed_decimal_field_formatter #(
    parameter int MAX_FIELD  = sdff_pkg::MAX_FIELD_DEF,
    parameter int VALUE_BITS = sdff_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sdff_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sdff_pkg::CHAR_W-1:0]         char_out,
    output logic                                last_char,
    output logic [sdff_pkg::LEN_PORT_W-1:0]     total_length,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdff_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdff_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sdff_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  neg_reg, neg_next;
    logic                  accept;
    logic [VALUE_BITS-1:0] raw, mag;
    logic                  bcd_busy, bcd_done, emit_busy;
    digits_t               digits;

    // Only the low VALUE_BITS bits of the beat are used, read as two's
    // complement. The magnitude fits in VALUE_BITS unsigned bits even for the
    // most negative value.
    assign raw = value[VALUE_BITS-1:0];
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    // The block is busy from the input beat until the last character has been
    // loaded into the output register.
    assign in_stall  = bcd_busy | emit_busy;
    assign accept    = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    // Register writes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        neg_next = neg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LAYOUT:     cfg_next.layout_mode     = cfg_data[1:0];
                REG_WIDTH:      cfg_next.field_width     = cfg_data[6:0];
                REG_PRECISION:  cfg_next.digit_precision = cfg_data[5:0];
                REG_LEFT:       cfg_next.left_justify    = cfg_data[0];
                REG_PREC_GIVEN: cfg_next.precision_given = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
        if (accept)
        begin
            neg_next = raw[VALUE_BITS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            neg_reg <= neg_next;
        end
    end

    sdff_bcd #(
        .VALUE_BITS (VALUE_BITS)
    ) u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mag    (mag),
        .busy   (bcd_busy),
        .done   (bcd_done),
        .digits (digits)
    );

    sdff_emit #(
        .MAX_FIELD (MAX_FIELD)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (bcd_done),
        .neg          (neg_reg),
        .digits       (digits),
        .cfg          (cfg_reg),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .char_out     (char_out),
        .last_char    (last_char),
        .total_length (total_length),
        .busy         (emit_busy)
    );

endmodule

@@ hw/rtl/sdff_chk.sv @@
// Port level checker for the signed decimal field formatter, bound to the top
// level below. Depends on sdff_pkg.
module sdff_chk #(
    parameter int MAX_FIELD = sdff_pkg::MAX_FIELD_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [sdff_pkg::CHAR_W-1:0]     char_out,
    input logic                            last_char,
    input logic [sdff_pkg::LEN_PORT_W-1:0] total_length
);
    import sdff_pkg::*;

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(last_char)
                                   && $stable(total_length))
        else $error("output beat changed while stalled");

    // Once a number is taken, the converter keeps the input stalled.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted beat");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_out == CHAR_SPACE) || (char_out == CHAR_MINUS)
                      || ((char_out >= CHAR_ZERO) && (char_out <= CHAR_NINE)))
        else $error("character outside the expected set");

    a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_char |-> total_length == '0)
        else $error("length shown on a character that is not the last");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_char |-> (total_length != '0)
                                   && (total_length <= LEN_PORT_W'(MAX_FIELD)))
        else $error("final length out of range");

endmodule

bind signed_decimal_field_formatter sdff_chk #(
    .MAX_FIELD (MAX_FIELD)
) u_sdff_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_out     (char_out),
    .last_char    (last_char),
    .total_length (total_length)
);

@@ dv/tb_signed_decimal_field_formatter.sv @@
// Self-checking testbench for the signed decimal field formatter: random and directed
// numbers under each layout mode, checked character by character.
// Depends on sdff_pkg and the signed_decimal_field_formatter RTL only.
module tb_signed_decimal_field_formatter;

    import sdff_pkg::*;

    // Layout code with no meaning of its own; the block treats it as width padding.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int FIELD_LIMIT = MAX_FIELD_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_WAIT = 13;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 64;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int PRINT_CAP = 50;

    // One character as the block should present it on the output channel.
    typedef struct {
        logic [CHAR_W-1:0]     ch;
        logic                  last;
        logic [LEN_PORT_W-1:0] len;
    } char_beat_t;

    // An entry of the sender's queue: either a number to format or a marker that
    // makes the sender wait until every character owed so far has come back.
    typedef struct {
        logic                      drain;
        logic signed [VALUE_W-1:0] val;
    } number_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [VALUE_W-1:0]    value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [CHAR_W-1:0]            char_out;
    logic                         last_char;
    logic [LEN_PORT_W-1:0]        total_length;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    signed_decimal_field_formatter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_out     (char_out),
        .last_char    (last_char),
        .total_length (total_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Our own copy of the layout registers, updated on every accepted write.
    logic [1:0] fmt_mode = MODE_WIDTH;
    logic [6:0] fmt_width = '0;
    logic [5:0] fmt_precision = '0;
    logic       fmt_left = 1'b0;
    logic       fmt_prec_given = 1'b0;

    number_entry_t numbers_to_send[$];
    char_beat_t    chars_owed[$];
    int            numbers_in_flight = 0;
    int            mismatch_count = 0;

    // Beat flags from the last rising edge, read by the falling-edge processes.
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    // Traffic shaping knobs set by the stimulus process.
    logic no_idle = 1'b0;
    int   long_holds_asked = 0;
    int   long_holds_done = 0;

    int sender_gap = 0;
    int receiver_wait = 0;
    int long_hold_left = 0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int floor_zero(input int x);
        return (x > 0) ? x : 0;
    endfunction

    // How long a side waits before its next beat; zero throughout a burst stretch.
    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Works out the text of one number under the current layout and appends its
    // characters to the list of those still owed by the block.
    function automatic void format_number(input logic signed [VALUE_W-1:0] v);
        logic              neg;
        logic [VALUE_W-1:0] mag;
        logic [DIG_W-1:0]  digs[DIGITS];
        logic [CHAR_W-1:0] text[$];
        int                nd;
        int                sign_len;
        int                zeros;
        int                spaces;
        int                body;
        char_beat_t        beat;

        neg = v[VALUE_W-1];
        mag = neg ? (~v + 1'b1) : v;
        sign_len = neg ? 1 : 0;

        // Digits come out least significant first; zero still gives one digit.
        nd = 0;
        do
        begin
            digs[nd] = DIG_W'(mag % 10);
            nd++;
            mag = mag / 10;
        end
        while (mag != 0);

        zeros = 0;
        spaces = 0;
        case (fmt_mode)
            MODE_ZERO:
            begin
                if (fmt_prec_given)
                    zeros = floor_zero(int'(fmt_precision) - nd);
                else
                    zeros = floor_zero(int'(fmt_width) - sign_len - nd);
            end
            MODE_PREC:
            begin
                zeros = floor_zero(int'(fmt_precision) - nd);
                spaces = floor_zero(int'(fmt_width) - sign_len - nd - zeros);
            end
            default:
                spaces = floor_zero(int'(fmt_width) - sign_len - nd);
        endcase

        // An oversized field loses zero fill first, then padding; digits always stay.
        if (zeros > FIELD_LIMIT - sign_len - nd)
            zeros = FIELD_LIMIT - sign_len - nd;
        body = sign_len + zeros + nd;
        if (spaces > FIELD_LIMIT - body)
            spaces = FIELD_LIMIT - body;

        if (!fmt_left)
            repeat (spaces) text.push_back(CHAR_SPACE);
        if (neg)
            text.push_back(CHAR_MINUS);
        repeat (zeros) text.push_back(CHAR_ZERO);
        for (int k = nd - 1; k >= 0; k--)
            text.push_back(CHAR_ZERO + digs[k]);
        if (fmt_left)
            repeat (spaces) text.push_back(CHAR_SPACE);

        foreach (text[k])
        begin
            beat.ch = text[k];
            beat.last = (k == text.size() - 1);
            beat.len = beat.last ? LEN_PORT_W'(text.size()) : '0;
            chars_owed.push_back(beat);
        end
    endfunction

    // Rising edge: record which beats moved, predict on each number taken and
    // check each character against the oldest one owed.
    always @(posedge clk)
    begin : observe
        char_beat_t want;

        in_taken <= rst_n && in_valid && !in_stall;
        out_taken <= rst_n && out_valid && !out_stall;

        if (rst_n && in_valid && !in_stall)
        begin
            format_number(value);
            numbers_in_flight--;
        end

        if (rst_n && out_valid && !out_stall)
        begin
            if (chars_owed.size() == 0)
                report_mismatch($sformatf("character 0x%02h with none owed", char_out));
            else
            begin
                want = chars_owed.pop_front();
                if (char_out !== want.ch)
                    report_mismatch($sformatf("char_out 0x%02h, wanted 0x%02h",
                                              char_out, want.ch));
                if (last_char !== want.last)
                    report_mismatch($sformatf("last_char %b, wanted %b",
                                              last_char, want.last));
                if (total_length !== want.len)
                    report_mismatch($sformatf("total_length %0d, wanted %0d",
                                              total_length, want.len));
            end
        end
    end

    // Falling edge: the sender offers the next number once its gap has run out.
    // A drain marker holds it back until the block has returned everything owed.
    always @(negedge clk)
    begin : sender
        logic          offer;
        number_entry_t entry;

        offer = in_valid && !in_taken;
        if (rst_n && !offer)
        begin
            if (sender_gap > 0)
                sender_gap--;
            else if (numbers_to_send.size() > 0)
            begin
                if (numbers_to_send[0].drain)
                begin
                    if (chars_owed.size() == 0)
                        void'(numbers_to_send.pop_front());
                end
                else
                begin
                    entry = numbers_to_send.pop_front();
                    value <= entry.val;
                    offer = 1'b1;
                    sender_gap = draw_wait();
                end
            end
        end
        in_valid <= offer;
    end

    // Falling edge: the receiver waits a drawn number of cycles after each
    // character, and on request refuses everything for a long stretch.
    always @(negedge clk)
    begin : receiver
        logic hold;

        hold = 1'b0;
        if (long_holds_done < long_holds_asked)
        begin
            long_holds_done++;
            long_hold_left = LONG_HOLD_CYCLES;
        end

        if (!rst_n)
            hold = 1'b0;
        else if (long_hold_left > 0)
        begin
            long_hold_left--;
            hold = 1'b1;
        end
        else if (receiver_wait > 0)
        begin
            receiver_wait--;
            hold = 1'b1;
        end
        else if (out_taken)
        begin
            receiver_wait = draw_wait();
            if (receiver_wait > 0)
            begin
                receiver_wait--;
                hold = 1'b1;
            end
        end
        out_stall <= hold;
    end

    task automatic send_number(input logic signed [VALUE_W-1:0] v);
        number_entry_t entry;

        entry.drain = 1'b0;
        entry.val = v;
        numbers_to_send.push_back(entry);
        numbers_in_flight++;
    endtask

    task automatic send_drain();
        number_entry_t entry;

        entry.drain = 1'b1;
        entry.val = '0;
        numbers_to_send.push_back(entry);
    endtask

    // The block is idle once nothing is queued, offered, or still owed.
    task automatic wait_idle();
        while (numbers_to_send.size() != 0 || numbers_in_flight != 0 ||
               chars_owed.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LAYOUT:     fmt_mode = data[1:0];
            REG_WIDTH:      fmt_width = data[6:0];
            REG_PRECISION:  fmt_precision = data[5:0];
            REG_LEFT:       fmt_left = data[0];
            REG_PREC_GIVEN: fmt_prec_given = data[0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_layout(input logic [1:0] mode, input logic [6:0] width,
                              input logic [5:0] precision, input logic left,
                              input logic prec_given);
        wait_idle();
        write_reg(REG_LAYOUT, CFG_DATA_W'(mode));
        write_reg(REG_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_PRECISION, CFG_DATA_W'(precision));
        write_reg(REG_LEFT, CFG_DATA_W'(left));
        write_reg(REG_PREC_GIVEN, CFG_DATA_W'(prec_given));
    endtask

    // Writes to the unused indexes must leave the layout untouched.
    task automatic poke_spare_regs();
        wait_idle();
        for (int i = REG_PREC_GIVEN + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    endtask

    // Field widths and precisions lean small so that most numbers stay short,
    // with the extremes drawn now and then.
    task automatic random_layout();
        logic [6:0] width;
        logic [5:0] precision;

        case ($urandom_range(0, 9))
            0:       width = 7'd0;
            1:       width = 7'd127;
            2:       width = 7'(FIELD_LIMIT);
            default: width = 7'($urandom_range(0, 20));
        endcase
        case ($urandom_range(0, 7))
            0:       precision = 6'd0;
            1:       precision = 6'd63;
            default: precision = 6'($urandom_range(0, 15));
        endcase
        set_layout(2'($urandom_range(0, 3)), width, precision,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Numbers spread over all sizes: raw random words, small counts, values next
    // to powers of ten where the digit count changes, and the two extremes.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        longint                    p;
        int                        sel;

        sel = $urandom_range(0, 5);
        case (sel)
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2:
            begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = VALUE_W'(p - 1 + $urandom_range(0, 2));
            end
            3: v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            default: v = $signed($urandom) >>> $urandom_range(0, 31);
        endcase
        if (sel >= 1 && sel <= 2 && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, first under the reset layout: zero, the extremes, and
        // values on either side of a change in digit count.
        send_number(0);
        send_number(1);
        send_number(-1);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
        send_number(9);
        send_number(10);
        send_number(-10);
        send_number(1_000_000_000);
        send_number(-999_999_999);

        set_layout(MODE_WIDTH, 7'd12, 6'd0, 1'b0, 1'b0);
        send_number(42);
        send_number(-42);
        set_layout(MODE_WIDTH, 7'd12, 6'd0, 1'b1, 1'b0);
        send_number(-7);
        set_layout(MODE_ZERO, 7'd12, 6'd3, 1'b0, 1'b0);
        send_number(-123);
        set_layout(MODE_ZERO, 7'd20, 6'd8, 1'b0, 1'b1);
        send_number(5);
        send_number(-5);
        // Zero at precision zero still prints its single digit.
        set_layout(MODE_PREC, 7'd5, 6'd0, 1'b0, 1'b0);
        send_number(0);
        // Oversized field: zero fill and padding are cut to fit the field limit.
        set_layout(MODE_PREC, 7'd127, 6'd63, 1'b0, 1'b0);
        send_number(32'sh8000_0000);
        send_number(1);
        // The unused layout code falls back to width padding.
        set_layout(MODE_UNUSED, 7'(FIELD_LIMIT), 6'd9, 1'b1, 1'b1);
        send_number(77);
        poke_spare_regs();
        set_layout(MODE_ZERO, 7'd127, 6'd0, 1'b0, 1'b0);
        send_number(-1);
        set_layout(MODE_WIDTH, 7'd127, 6'd63, 1'b0, 1'b1);
        send_number(3);

        // Random part: eight settings of the layout, twenty numbers under each.
        for (int phase = 0; phase < 8; phase++)
        begin
            random_layout();
            if (phase == 6)
                poke_spare_regs();
            no_idle = (phase == 1 || phase == 5);
            for (int n = 0; n < 20; n++)
            begin
                send_number(pick_value());
                if (phase == 3 && n % 5 == 4)
                    send_drain();
            end
            // Refuse output for a long stretch while numbers keep coming, so the
            // block fills up and stalls its input beat.
            if (phase == 1)
                long_holds_asked++;
        end

        wait_idle();
        no_idle = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

endmodule
